// ----- hw/rtl/p2pd_pkg.sv -----
// ----------------------------------------------------------------------------
// p2pd_pkg: shared types and constants
// widths, register indexes and sequencer states for the plane distance core
// ----------------------------------------------------------------------------
package p2pd_pkg;

    localparam int unsigned CoordW  = 32;
    localparam int unsigned NormW   = 18;
    localparam int unsigned DiffW   = CoordW + 1;
    localparam int unsigned ProdW   = DiffW + NormW;
    localparam int unsigned DotW    = ProdW + 2;
    localparam int unsigned MagW    = 52;
    localparam int unsigned RootW   = 32;
    localparam int unsigned DistW   = 34;
    localparam int unsigned SumW    = 36;
    localparam int unsigned RadW    = 64;
    localparam int unsigned RemW    = RootW + 2;
    localparam int unsigned PreShift = 20;
    localparam int unsigned LowPad  = 14;

    localparam logic [DistW-1:0] DistMax  = '1;
    localparam logic [NormW-1:0] NormZRst = 18'sd65536;

    typedef enum logic [2:0] {
        REG_REF_X    = 3'd0,
        REG_REF_Y    = 3'd1,
        REG_REF_Z    = 3'd2,
        REG_NORMAL_X = 3'd3,
        REG_NORMAL_Y = 3'd4,
        REG_NORMAL_Z = 3'd5
    } t_reg_idx;

    typedef enum logic [1:0] {
        SQ_IDLE,
        SQ_SUM,
        SQ_ROOT
    } t_sq_state;

endpackage

// ----- hw/rtl/point_to_plane_distance_core.sv -----
// ----------------------------------------------------------------------------
// point_to_plane_distance_core: distance from a point to a configured plane
// |dot(p - ref, n)| / |n| in fixed point, pipelined one word per cycle
// ----------------------------------------------------------------------------
// channel  dir  width  content
// s        in   96     point_x [31:0], point_y [63:32], point_z [95:64]
// m        out  40+1   tdata distance [33:0] (zero pad), tuser degenerate
// apb      in   5/32   ref_x..normal_z at byte address 4*index
//
// one word enters per cycle while the output is not stalled and |n| is not
// being rebuilt; stages: difference, product, sum, range check, then 34
// restoring divide stages, one quotient bit each; the whole pipe advances
// together; a stalled output freezes every stage. after reset and after
// each register write the magnitude |n| is rebuilt (n.n, then a bit-serial
// square root), during which s_tready is low
// ----------------------------------------------------------------------------
module point_to_plane_distance_core
    import p2pd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [95:0] i_s_tdata,   // point_x, point_y, point_z
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // distance, zero pad
    output logic        o_m_tuser,   // degenerate
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned NDiv = DistW;

    // configuration registers
    logic signed [CoordW-1:0] r_ref [3];
    logic signed [NormW-1:0]  r_nrm [3];
    logic [2:0] w_idx;
    logic       w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[4:2];
    assign w_wr   = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref[0] <= '0;
            r_ref[1] <= '0;
            r_ref[2] <= '0;
            r_nrm[0] <= '0;
            r_nrm[1] <= '0;
            r_nrm[2] <= NormZRst;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_REF_X:    r_ref[0] <= pwdata;
                REG_REF_Y:    r_ref[1] <= pwdata;
                REG_REF_Z:    r_ref[2] <= pwdata;
                REG_NORMAL_X: r_nrm[0] <= pwdata[NormW-1:0];
                REG_NORMAL_Y: r_nrm[1] <= pwdata[NormW-1:0];
                REG_NORMAL_Z: r_nrm[2] <= pwdata[NormW-1:0];
                default: ;  // unmapped addresses ignore writes
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_REF_X:    prdata = r_ref[0];
            REG_REF_Y:    prdata = r_ref[1];
            REG_REF_Z:    prdata = r_ref[2];
            REG_NORMAL_X: prdata = 32'(r_nrm[0]);
            REG_NORMAL_Y: prdata = 32'(r_nrm[1]);
            REG_NORMAL_Z: prdata = 32'(r_nrm[2]);
            default:      prdata = '0;
        endcase
    end

    // magnitude sequencer: S = n.n, R = isqrt(S << 28)
    t_sq_state           r_st, n_st;
    logic [4:0]          r_cnt, n_cnt;
    logic [RadW-1:0]     r_rad, n_rad;
    logic [RemW-1:0]     r_rem, n_rem;
    logic [RootW-1:0]    r_root, n_root;
    logic                r_deg, n_deg;
    logic [SumW-1:0]     w_sum;
    logic [RemW+1:0]     w_rt;
    logic [RemW+1:0]     w_trial;

    assign w_sum = SumW'(r_nrm[0] * r_nrm[0]) + SumW'(r_nrm[1] * r_nrm[1])
                 + SumW'(r_nrm[2] * r_nrm[2]);
    assign w_rt    = {r_rem, r_rad[RadW-1 -: 2]};
    assign w_trial = (RemW+2)'({r_root, 2'b01});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= SQ_SUM;
            r_cnt <= '0;
        end else begin
            r_st  <= n_st;
            r_cnt <= n_cnt;
        end
        r_rad  <= n_rad;
        r_rem  <= n_rem;
        r_root <= n_root;
        r_deg  <= n_deg;
    end

    always_comb begin
        n_st   = r_st;
        n_cnt  = r_cnt;
        n_rad  = r_rad;
        n_rem  = r_rem;
        n_root = r_root;
        n_deg  = r_deg;
        unique case (r_st)
            SQ_IDLE: ;
            SQ_SUM: begin
                n_rad  = {w_sum[SumW-1:0], 28'b0};
                n_rem  = '0;
                n_root = '0;
                n_cnt  = '0;
                n_deg  = (w_sum == '0);
                n_st   = SQ_ROOT;
            end
            SQ_ROOT: begin
                n_rad = {r_rad[RadW-3:0], 2'b00};
                if (w_rt >= w_trial) begin
                    n_rem  = RemW'(w_rt - w_trial);
                    n_root = {r_root[RootW-2:0], 1'b1};
                end else begin
                    n_rem  = RemW'(w_rt);
                    n_root = {r_root[RootW-2:0], 1'b0};
                end
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == 5'd31) n_st = SQ_IDLE;
            end
            default: n_st = SQ_SUM;
        endcase
        if (w_wr) n_st = SQ_SUM;   // any write rebuilds the magnitude
    end

    // datapath pipeline
    logic w_en;
    logic r_v1, r_v2, r_v3, r_v4;
    logic signed [DiffW-1:0] r_d [3];
    logic signed [ProdW-1:0] r_p [3];
    logic [MagW-1:0]         r_mag;
    logic signed [DotW-1:0]  w_dot;
    logic                    r_dg1, r_dg2, r_dg3;
    logic                    r_v  [NDiv+1];
    logic                    r_sat[NDiv+1];
    logic                    r_dg [NDiv+1];
    logic [RootW-1:0]        r_qr [NDiv+1];  // partial remainder
    logic [DistW-1:0]        r_qw [NDiv+1];  // dividend bits / quotient bits

    assign w_en       = !r_v[NDiv] || i_m_tready;
    assign o_s_tready = w_en && (r_st == SQ_IDLE);

    assign w_dot = DotW'(r_p[0]) + DotW'(r_p[1]) + DotW'(r_p[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_s_tvalid && o_s_tready;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_d[k] <= DiffW'($signed(i_s_tdata[k*CoordW +: CoordW]))
                        - DiffW'(r_ref[k]);
                r_p[k] <= ProdW'(r_d[k]) * ProdW'(r_nrm[k]);
            end
            r_dg1 <= r_deg;
            r_dg2 <= r_dg1;
            r_dg3 <= r_dg2;
            r_mag <= w_dot[DotW-1] ? MagW'(-w_dot) : MagW'(w_dot);
        end
    end

    assign r_v4 = r_v3;

    // range check and divider seed, then one quotient bit per stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NDiv; k++) r_v[k] <= 1'b0;
        end else if (w_en) begin
            r_v[0] <= r_v4;
            for (int k = 1; k <= NDiv; k++) r_v[k] <= r_v[k-1];
        end
        if (w_en) begin
            r_sat[0] <= r_mag >= {r_root, PreShift'(0)};
            r_dg[0]  <= r_dg3;
            r_qr[0]  <= r_mag[MagW-1 -: RootW];
            r_qw[0]  <= {r_mag[PreShift-1:0], LowPad'(0)};
            for (int k = 1; k <= NDiv; k++) begin
                r_sat[k] <= r_sat[k-1];
                r_dg[k]  <= r_dg[k-1];
            end
        end
    end

    genvar g;
    generate
        for (g = 1; g <= NDiv; g++) begin : g_div
            logic [RootW:0] w_t;
            logic           w_ge;
            assign w_t  = {r_qr[g-1], r_qw[g-1][DistW-1]};
            assign w_ge = w_t >= {1'b0, r_root};
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_qr[g] <= w_ge ? RootW'(w_t - {1'b0, r_root}) : RootW'(w_t);
                    r_qw[g] <= {r_qw[g-1][DistW-2:0], w_ge};
                end
            end
        end
    endgenerate

    // output
    logic [DistW-1:0] w_dist;
    assign w_dist = r_dg[NDiv] ? '0 : (r_sat[NDiv] ? DistMax : r_qw[NDiv]);

    assign o_m_tvalid = r_v[NDiv];
    assign o_m_tdata  = {6'b0, w_dist};
    assign o_m_tuser  = r_dg[NDiv];

endmodule

// ----- hw/rtl/p2pd_checker.sv -----
// ----------------------------------------------------------------------------
// p2pd_checker: port-level checks for the plane distance core
// watches the stream and register ports over time
// ----------------------------------------------------------------------------
module p2pd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [39:0] o_m_tdata,
    input logic        o_m_tuser,
    input logic        psel,
    input logic        penable,
    input logic        pwrite
);

    // degenerate words carry zero distance
    a_deg_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata == 40'd0)
        else $error("degenerate word with nonzero distance");

    // a register write blocks input while the magnitude is rebuilt
    a_wr_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite |=> !o_s_tready)
        else $error("input accepted right after a register write");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser))
        else $error("stalled output word changed");

endmodule

bind point_to_plane_distance_core p2pd_checker u_p2pd_checker (.*);
